// ===== rtl/mip_chain_layout_checker_core_macros.svh =====
// Assertion macros shared by the mip chain layout checker.
`ifndef MIP_CHAIN_LAYOUT_CHECKER_CORE_MACROS_SVH
`define MIP_CHAIN_LAYOUT_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MCLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mclc_pkg.sv =====
// Types, codes and helper functions of the mip chain layout checker.
`default_nettype none
package mclc_pkg;

  localparam logic [31:0] TEX_MAGIC   = 32'h4854_5841;
  localparam logic [15:0] TEX_VERSION = 16'd1;

  localparam logic [7:0] FMT_RGBA8 = 8'd0;
  localparam logic [7:0] FMT_RGB8  = 8'd1;
  localparam logic [7:0] FMT_BC1   = 8'd2;
  localparam logic [7:0] FMT_BC3   = 8'd3;
  localparam logic [7:0] FMT_BC4   = 8'd4;
  localparam logic [7:0] FMT_BC5   = 8'd5;
  localparam logic [7:0] FMT_BC7   = 8'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_SHORT    = 3'd1,
    STATUS_MAGIC    = 3'd2,
    STATUS_VERSION  = 3'd3,
    STATUS_ZERO     = 3'd4,
    STATUS_LEVELS   = 3'd5,
    STATUS_MISMATCH = 3'd6,
    STATUS_TRUNC    = 3'd7
  } status_t;

  // Bytes per pixel for plain formats, bytes per 4x4 block for BC formats.
  typedef enum logic [1:0] {
    SCALE_PX4,
    SCALE_PX3,
    SCALE_BLK8,
    SCALE_BLK16
  } scale_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic        last;
    logic [3:0]  idx;
    status_t     status;
    logic [31:0] w;
    logic [31:0] h;
    scale_t      scale;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] val;
  } lvl_t;

  function automatic scale_t scale_of(input logic [7:0] fmt);
    scale_t s;
    case (fmt)
      FMT_RGBA8: s = SCALE_PX4;
      FMT_RGB8:  s = SCALE_PX3;
      FMT_BC1:   s = SCALE_BLK8;
      FMT_BC4:   s = SCALE_BLK8;
      FMT_BC3:   s = SCALE_BLK16;
      FMT_BC5:   s = SCALE_BLK16;
      FMT_BC7:   s = SCALE_BLK16;
      default:   s = SCALE_PX4;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] halve_floor1(input logic [31:0] d);
    logic [31:0] q;
    q = d >> 1;
    return (q == 32'd0) ? 32'd1 : q;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mip_chain_layout_checker_core.sv =====
// Mip chain layout checker: header validation and per-level offset/size pipeline.
//
// Pulse start while busy is low to hand in one texture header. The header is
// checked in the cycle after it is accepted; a failed check produces a single
// result with level_valid low and last high. A good header is stepped through
// its mip levels by a sequencer that issues one level per cycle into a
// five-register pipeline (level issue, operand select, 32x32 multiply, byte
// scaling, offset accumulate / output). Each result is shown for one cycle with
// result_valid high and must be taken then: there is no back-pressure. busy
// stays high until the last result has left, so a new header can only be
// accepted once the previous one has fully drained. level_index counts modulo
// 16; offsets and sizes wrap at 32 bits.
`default_nettype none
`include "mip_chain_layout_checker_core_macros.svh"
module mip_chain_layout_checker_core #(
  parameter int MAX_LEVELS   = 16,
  parameter int HEADER_BYTES = 36
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] magic,
  input  wire logic [15:0] version,
  input  wire logic [7:0]  format,
  input  wire logic [7:0]  level_count,
  input  wire logic [31:0] base_width,
  input  wire logic [31:0] base_height,
  input  wire logic [31:0] declared_size,
  input  wire logic [31:0] total_bytes,
  output logic             result_valid,
  output logic [3:0]       level_index,
  output logic [31:0]      level_offset,
  output logic [31:0]      level_bytes,
  output logic [31:0]      level_width,
  output logic [31:0]      level_height,
  output logic             level_valid,
  output logic             last,
  output logic [2:0]       status
);

  localparam int CW = $clog2(MAX_LEVELS + 1);

  mclc_pkg::state_t state, state_next;

  // captured header
  logic [31:0] c_magic;
  logic [15:0] c_version;
  logic [7:0]  c_format;
  logic [7:0]  c_levels;
  logic [31:0] c_declared;
  logic [31:0] c_total;
  logic [31:0] cur_w, cur_h;
  logic        trunc;

  logic [CW-1:0] cnt;

  mclc_pkg::lvl_t s1, s1_next, s2, s2_next, s3, s3_next, s4, s4_next;

  logic [31:0] run_off;
  logic [31:0] off_sum;
  logic        accept;
  logic        pipe_empty;
  logic        issue_last;
  mclc_pkg::status_t early_st;

  assign accept     = start && !busy;
  assign busy       = (state != mclc_pkg::ST_IDLE);
  assign pipe_empty = !(s1.valid || s2.valid || s3.valid || s4.valid || result_valid);
  assign issue_last = ((8'(cnt) + 8'd1) == c_levels);

  // header checks in priority order
  always_comb begin
    if (c_total < 32'(HEADER_BYTES)) begin
      early_st = mclc_pkg::STATUS_SHORT;
    end else if (c_magic != mclc_pkg::TEX_MAGIC) begin
      early_st = mclc_pkg::STATUS_MAGIC;
    end else if (c_version != mclc_pkg::TEX_VERSION) begin
      early_st = mclc_pkg::STATUS_VERSION;
    end else if (cur_w == 32'd0 || cur_h == 32'd0 || c_levels == 8'd0) begin
      early_st = mclc_pkg::STATUS_ZERO;
    end else if (c_levels > 8'(MAX_LEVELS)) begin
      early_st = mclc_pkg::STATUS_LEVELS;
    end else begin
      early_st = mclc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mclc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    s1_next            = s1;
    s1_next.valid      = 1'b0;
    case (state)
      mclc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = mclc_pkg::ST_CHECK;
        end
      end
      mclc_pkg::ST_CHECK: begin
        if (early_st != mclc_pkg::STATUS_OK) begin
          // inject a single error word
          s1_next.valid  = 1'b1;
          s1_next.err    = 1'b1;
          s1_next.last   = 1'b1;
          s1_next.idx    = 4'd0;
          s1_next.status = early_st;
          s1_next.w      = 32'd1;
          s1_next.h      = 32'd1;
          s1_next.scale  = mclc_pkg::SCALE_PX4;
          state_next     = mclc_pkg::ST_DRAIN;
        end else begin
          state_next = mclc_pkg::ST_ISSUE;
        end
      end
      mclc_pkg::ST_ISSUE: begin
        s1_next.valid  = 1'b1;
        s1_next.err    = 1'b0;
        s1_next.last   = issue_last;
        s1_next.idx    = 4'(cnt);
        s1_next.status = mclc_pkg::STATUS_OK;
        s1_next.w      = cur_w;
        s1_next.h      = cur_h;
        s1_next.scale  = mclc_pkg::scale_of(c_format);
        if (issue_last) begin
          state_next = mclc_pkg::ST_DRAIN;
        end
      end
      mclc_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = mclc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mclc_pkg::ST_IDLE;
      end
    endcase
  end

  // header capture and level stepping
  always_ff @(posedge clk) begin
    if (accept) begin
      c_magic    <= magic;
      c_version  <= version;
      c_format   <= format;
      c_levels   <= level_count;
      c_declared <= declared_size;
      c_total    <= total_bytes;
      cur_w      <= base_width;
      cur_h      <= base_height;
    end else if (state == mclc_pkg::ST_ISSUE) begin
      cur_w <= mclc_pkg::halve_floor1(cur_w);
      cur_h <= mclc_pkg::halve_floor1(cur_h);
    end
    if (state == mclc_pkg::ST_CHECK) begin
      trunc <= (c_declared > (c_total - 32'(HEADER_BYTES)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == mclc_pkg::ST_ISSUE) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // stage 2: pick pixel or block dimensions
  always_comb begin
    logic blk;
    blk     = (s1.scale == mclc_pkg::SCALE_BLK8) || (s1.scale == mclc_pkg::SCALE_BLK16);
    s2_next = s1;
    s2_next.opa = blk ? (32'(s1.w + 32'd3) >> 2) : s1.w;
    s2_next.opb = blk ? (32'(s1.h + 32'd3) >> 2) : s1.h;
  end

  // stage 3: element count, low 32 bits
  always_comb begin
    s3_next     = s2;
    s3_next.val = 32'(s2.opa * s2.opb);
  end

  // stage 4: scale count to bytes
  always_comb begin
    s4_next = s3;
    case (s3.scale)
      mclc_pkg::SCALE_PX4:   s4_next.val = s3.val << 2;
      mclc_pkg::SCALE_PX3:   s4_next.val = 32'(s3.val + (s3.val << 1));
      mclc_pkg::SCALE_BLK8:  s4_next.val = s3.val << 3;
      mclc_pkg::SCALE_BLK16: s4_next.val = s3.val << 4;
      default:               s4_next.val = s3.val << 2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
    end else begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
    end
  end

  // stage 5: accumulate offset, final status, drive result word
  assign off_sum = 32'(run_off + s4.val);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      run_off      <= 32'd0;
    end else begin
      result_valid <= s4.valid;
      if (s4.valid && !s4.err) begin
        run_off <= s4.last ? 32'd0 : off_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    level_index  <= s4.idx;
    level_width  <= s4.w;
    level_height <= s4.h;
    level_valid  <= !s4.err;
    last         <= s4.last;
    if (s4.err) begin
      level_offset <= 32'd0;
      level_bytes  <= 32'd0;
      status       <= s4.status;
    end else begin
      level_offset <= run_off;
      level_bytes  <= s4.val;
      if (!s4.last) begin
        status <= mclc_pkg::STATUS_OK;
      end else if (off_sum != c_declared) begin
        status <= mclc_pkg::STATUS_MISMATCH;
      end else if (trunc) begin
        status <= mclc_pkg::STATUS_TRUNC;
      end else begin
        status <= mclc_pkg::STATUS_OK;
      end
    end
  end

  `MCLC_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `MCLC_ASSERT_NOW(a_result_in_busy, clk, rst, result_valid, busy)
  `MCLC_ASSERT_NOW(a_error_is_last, clk, rst, result_valid && !level_valid, last)
  `MCLC_ASSERT_NOW(a_dims_nonzero, clk, rst, result_valid && level_valid,
                   level_width != 32'd0 && level_height != 32'd0)

endmodule
`default_nettype wire
